[rtl/vpma_pkg.sv]
package vpma_pkg;

	localparam int PLANE_BYTES = 65536;
	localparam int OFS_W       = $clog2(PLANE_BYTES);
	localparam int NUM_PLANES  = 4;
	localparam int ADDR_W      = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [1:0] {
		CMD_MEM_RD   = 2'd0,
		CMD_MEM_WR   = 2'd1,
		CMD_LATCH_RD = 2'd2,
		CMD_LATCH_WR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SET_RESET     = 3'd0,
		REG_ENABLE_SR     = 3'd1,
		REG_COLOR_COMPARE = 3'd2,
		REG_ROTATE_OP     = 3'd3,
		REG_READ_MAP      = 3'd4,
		REG_ACCESS_MODE   = 3'd5,
		REG_BIT_MASK      = 3'd6,
		REG_MAP_MASK      = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_COPY = 2'd0,
		OP_AND  = 2'd1,
		OP_OR   = 2'd2,
		OP_XOR  = 2'd3
	} alu_op_t;

	typedef enum logic [1:0] {
		WM_ROTATE  = 2'd0,
		WM_LATCH   = 2'd1,
		WM_EXPAND  = 2'd2,
		WM_MASKED  = 2'd3
	} write_mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic exec;         // non-read command handled in the accept cycle
		logic issue_read;   // start a memory read on all banks
		logic finish_read;  // bank data is valid, form the result
	} dp_cmd_t;

	typedef struct packed {
		logic mem_read;
	} dp_status_t;

endpackage

[rtl/vpma_ram.sv]
module vpma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

[rtl/vpma_ctrl.sv]
module vpma_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  vpma_pkg::dp_status_t status,
	output vpma_pkg::dp_cmd_t    cmd,
	output logic                 busy
);
	import vpma_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (status.mem_read) begin
						cmd.issue_read = 1'b1;
						state_d        = ST_READ;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			ST_READ: begin
				busy            = 1'b1;
				cmd.finish_read = 1'b1;
				state_d         = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[rtl/vpma_datapath.sv]
module vpma_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vpma_pkg::dp_cmd_t                    cmd,
	output vpma_pkg::dp_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [vpma_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vpma_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [1:0]                           command,
	input  logic [vpma_pkg::ADDR_W-1:0]          address,
	input  logic [7:0]                           write_data,
	input  logic [1:0]                           latch_select,
	output logic                                 done,
	output logic [7:0]                           read_data
);
	import vpma_pkg::*;

	logic [3:0] set_reset_q, enable_sr_q, map_mask_q, access_mode_q;
	logic [7:0] color_compare_q, bit_mask_q;
	logic [4:0] rotate_op_q;
	logic [1:0] read_map_q;

	logic [7:0] latch_q [NUM_PLANES];
	logic [1:0] bank_q;
	logic       done_q;
	logic [7:0] read_data_q;

	logic [1:0]       bank;
	logic [OFS_W-1:0] offset;
	logic [7:0]       rotated;
	logic [15:0]      doubled;
	logic [7:0]       plane_val [NUM_PLANES];
	logic [7:0]       bank_wdata [NUM_PLANES];
	logic             bank_we [NUM_PLANES];
	logic [7:0]       bank_rdata [NUM_PLANES];
	logic [7:0]       plane_rd [NUM_PLANES];
	logic [7:0]       compare_res;
	logic [7:0]       read_res;

	function automatic logic [7:0] alu(input logic [1:0] op, input logic [7:0] v,
	                                   input logic [7:0] latch);
		logic [7:0] r;
		case (op)
			OP_AND:  r = v & latch;
			OP_OR:   r = v | latch;
			OP_XOR:  r = v ^ latch;
			default: r = v;
		endcase
		return r;
	endfunction

	assign status.mem_read = (cmd_t'(command) == CMD_MEM_RD);
	assign bank   = address[OFS_W+1:OFS_W];
	assign offset = address[OFS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_reset_q     <= '0;
			enable_sr_q     <= '0;
			color_compare_q <= '0;
			rotate_op_q     <= '0;
			read_map_q      <= '0;
			access_mode_q   <= 4'd8;
			bit_mask_q      <= 8'hFF;
			map_mask_q      <= 4'hF;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SET_RESET:     set_reset_q     <= cfg_data[3:0];
				REG_ENABLE_SR:     enable_sr_q     <= cfg_data[3:0];
				REG_COLOR_COMPARE: color_compare_q <= cfg_data;
				REG_ROTATE_OP:     rotate_op_q     <= cfg_data[4:0];
				REG_READ_MAP:      read_map_q      <= cfg_data[1:0];
				REG_ACCESS_MODE:   access_mode_q   <= cfg_data[3:0];
				REG_BIT_MASK:      bit_mask_q      <= cfg_data;
				REG_MAP_MASK:      map_mask_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Rotate right by the count: take the low byte of the doubled word shifted.
	assign doubled = {write_data, write_data} >> rotate_op_q[2:0];
	assign rotated = doubled[7:0];

	always_comb begin
		logic [7:0] sr, v, m;
		for (int p = 0; p < NUM_PLANES; p++) begin
			sr = {8{set_reset_q[p]}};
			m  = bit_mask_q;
			case (write_mode_t'(access_mode_q[1:0]))
				WM_ROTATE: v = alu(rotate_op_q[4:3], enable_sr_q[p] ? sr : rotated,
				                   latch_q[p]);
				WM_LATCH: begin
					v = latch_q[p];
					m = 8'hFF;
				end
				WM_EXPAND: v = alu(rotate_op_q[4:3], {8{write_data[p]}}, latch_q[p]);
				default: begin
					v = alu(rotate_op_q[4:3], sr, latch_q[p]);
					m = rotated & bit_mask_q;
				end
			endcase
			plane_val[p] = (v & m) | (latch_q[p] & ~m);
		end
	end

	// Bank k holds plane (k - bank) of the addressed byte.
	always_comb begin
		logic [1:0] pl;
		for (int k = 0; k < NUM_PLANES; k++) begin
			pl = 2'(k) - bank;
			if (access_mode_q[3]) begin
				bank_we[k]    = cmd.exec && (cmd_t'(command) == CMD_MEM_WR) && (2'(k) == bank);
				bank_wdata[k] = write_data;
			end else begin
				bank_we[k]    = cmd.exec && (cmd_t'(command) == CMD_MEM_WR) && map_mask_q[pl];
				bank_wdata[k] = plane_val[pl];
			end
		end
	end

	for (genvar k = 0; k < NUM_PLANES; k++) begin : g_bank
		vpma_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_ram (
			.clk   (clk),
			.we    (bank_we[k]),
			.re    (cmd.issue_read),
			.addr  (offset),
			.wdata (bank_wdata[k]),
			.rdata (bank_rdata[k])
		);
	end

	always_comb begin
		compare_res = 8'hFF;
		for (int p = 0; p < NUM_PLANES; p++) begin
			plane_rd[p] = bank_rdata[2'(p) + bank_q];
			if (color_compare_q[4+p]) begin
				compare_res = compare_res & ~(plane_rd[p] ^ {8{color_compare_q[p]}});
			end
		end
		if (access_mode_q[3]) begin
			read_res = bank_rdata[bank_q];
		end else if (access_mode_q[2]) begin
			read_res = compare_res;
		end else begin
			read_res = plane_rd[read_map_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_read) begin
			bank_q <= bank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				latch_q[p] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec | cmd.finish_read;
			if (cmd.finish_read && !access_mode_q[3]) begin
				for (int p = 0; p < NUM_PLANES; p++) begin
					latch_q[p] <= plane_rd[p];
				end
			end else if (cmd.exec && cmd_t'(command) == CMD_LATCH_WR) begin
				latch_q[latch_select] <= write_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_read) begin
			read_data_q <= read_res;
		end else if (cmd.exec) begin
			read_data_q <= (cmd_t'(command) == CMD_LATCH_RD) ? latch_q[latch_select] : 8'h00;
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;
endmodule

[rtl/vga_planar_memory_access_unit.sv]
// Channel   Handshake              Payload
// command   start / busy           command, address, write_data, latch_select
// result    done (one-cycle pulse) read_data
// config    cfg_we                 cfg_index, cfg_data
//
// In a memory read the four plane banks are read in the accept cycle and the
// registered bank data is combined in the next, so busy is high for one cycle.
// Writes and latch accesses are handled in the accept cycle with busy staying low.
// done pulses in the cycle after the last work cycle; the receiver cannot stall.
// Reset loads config defaults and clears the latches; display memory is not cleared.
module vga_planar_memory_access_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           command,
	input  logic [vpma_pkg::ADDR_W-1:0]          address,
	input  logic [7:0]                           write_data,
	input  logic [1:0]                           latch_select,
	output logic                                 done,
	output logic [7:0]                           read_data,
	input  logic                                 cfg_we,
	input  logic [vpma_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vpma_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import vpma_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	vpma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (dp_status),
		.cmd    (dp_cmd),
		.busy   (busy)
	);

	vpma_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.address      (address),
		.write_data   (write_data),
		.latch_select (latch_select),
		.done         (done),
		.read_data    (read_data)
	);
endmodule

[rtl/vpma_checker.sv]
module vpma_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] command,
	input logic       done,
	input logic [7:0] read_data
);
	import vpma_pkg::*;

	logic accept;
	assign accept = start && !busy;

	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command != CMD_MEM_RD |=> done && !busy)
		else $error("non-read transfer did not complete in one cycle");

	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_MEM_RD |=> busy && !done ##1 done && !busy)
		else $error("memory read timing wrong");

	a_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_MEM_WR || command == CMD_LATCH_WR) |=> read_data == 8'h00)
		else $error("write returned non-zero data");

	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");
endmodule

bind vga_planar_memory_access_unit vpma_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.command   (command),
	.done      (done),
	.read_data (read_data)
);

[tb/sv/tb_top.sv]
module tb_top;
	import vpma_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int POOL_N       = 16;
	localparam int MODE_READ1   = 4;
	localparam int MODE_LINEAR  = 8;

	// Predicts the returned byte of every accepted transfer and checks done pulses.
	class vga_scoreboard;
		bit [7:0] vram [int];
		bit [7:0] latches [NUM_PLANES];
		bit [7:0] regs [8];
		bit [7:0] pending_bytes [$];
		int       errors;

		function new();
			regs = '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd8, 8'hFF, 8'hF};
			foreach (latches[i]) latches[i] = 8'h0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function bit [7:0] peek(int a);
			return vram.exists(a) ? vram[a] : 8'h00;
		endfunction

		function bit [7:0] rotated(bit [7:0] d);
			bit [15:0] w;
			w = {d, d} >> regs[REG_ROTATE_OP][2:0];
			return w[7:0];
		endfunction

		function bit [7:0] apply_op(bit [7:0] v, bit [7:0] l);
			case (alu_op_t'(regs[REG_ROTATE_OP][4:3]))
				OP_AND:  return v & l;
				OP_OR:   return v | l;
				OP_XOR:  return v ^ l;
				default: return v;
			endcase
		endfunction

		function bit [7:0] planar_read(int a);
			bit [7:0] r;
			bit [7:0] cc;
			cc = regs[REG_COLOR_COMPARE];
			for (int p = 0; p < NUM_PLANES; p++)
				latches[p] = peek((a + p * PLANE_BYTES) % (NUM_PLANES * PLANE_BYTES));
			if (regs[REG_ACCESS_MODE] & MODE_READ1) begin
				r = 8'hFF;
				for (int p = 0; p < NUM_PLANES; p++)
					if (cc[4 + p])
						r &= ~(latches[p] ^ {8{cc[p]}});
				return r;
			end
			return latches[regs[REG_READ_MAP][1:0]];
		endfunction

		function void planar_write(int a, bit [7:0] d);
			bit [7:0] rot, sr, val, m, l;
			rot = rotated(d);
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (!regs[REG_MAP_MASK][p])
					continue;
				l  = latches[p];
				sr = {8{regs[REG_SET_RESET][p]}};
				m  = regs[REG_BIT_MASK];
				case (write_mode_t'(regs[REG_ACCESS_MODE][1:0]))
					WM_ROTATE: val = apply_op(regs[REG_ENABLE_SR][p] ? sr : rot, l);
					WM_LATCH: begin
						val = l;
						m = 8'hFF;
					end
					WM_EXPAND: val = apply_op({8{d[p]}}, l);
					default: begin
						val = apply_op(sr, l);
						m = rot & regs[REG_BIT_MASK];
					end
				endcase
				vram[(a + p * PLANE_BYTES) % (NUM_PLANES * PLANE_BYTES)] = (val & m) | (l & ~m);
			end
		endfunction

		function void note(cmd_t cmd, bit [17:0] addr, bit [7:0] d, bit [1:0] sel);
			bit [7:0] r;
			int a;
			a = addr;
			r = 8'h00;
			case (cmd)
				CMD_MEM_RD:
					r = (regs[REG_ACCESS_MODE] & MODE_LINEAR) ? peek(a) : planar_read(a);
				CMD_MEM_WR:
					if (regs[REG_ACCESS_MODE] & MODE_LINEAR) vram[a] = d;
					else planar_write(a, d);
				CMD_LATCH_RD: r = latches[sel];
				default: latches[sel] = d;
			endcase
			pending_bytes.push_back(r);
		endfunction

		task check(bit [7:0] got);
			bit [7:0] want;
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected result %02h", got));
			end else begin
				want = pending_bytes.pop_front();
				if (got !== want)
					report($sformatf("read_data %02h, expected %02h", got, want));
			end
		endtask
	endclass

	logic       clk, arst_n, start, busy, done, cfg_we;
	logic [1:0] command, latch_select;
	logic [17:0] address;
	logic [7:0] write_data, read_data, cfg_data;
	logic [2:0] cfg_index;

	vga_scoreboard sb;
	bit [15:0] pool [POOL_N];
	bit [7:0]  cfg_val [8];
	bit        no_gaps;
	int        cycles = 0;

	vga_planar_memory_access_unit DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check(read_data);

	// Leaves start high; the caller lowers it only when a gap follows.
	task send(cmd_t cmd, bit [17:0] addr, bit [7:0] d, bit [1:0] sel);
		start        <= 1'b1;
		command      <= cmd;
		address      <= addr;
		write_data   <= d;
		latch_select <= sel;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note(cmd, addr, d, sel);
	endtask

	task pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task drain();
		pause(1);
		while (sb.pending_bytes.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task program_regs();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= cfg_val[i];
			@(posedge clk);
			sb.regs[i] = cfg_val[i];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function bit [17:0] pool_addr();
		return {2'($urandom_range(0, 3)), pool[$urandom_range(0, POOL_N - 1)]};
	endfunction

	task random_item();
		int k;
		k = $urandom_range(0, 9);
		if (k < 3)
			send(CMD_MEM_RD, pool_addr(), 8'($urandom), 2'($urandom));
		else if (k < 5)
			send(CMD_MEM_WR, pool_addr(), 8'($urandom), 2'($urandom));
		else if (k < 6)
			send(CMD_MEM_WR, 18'($urandom), 8'($urandom), 2'($urandom));
		else if (k < 8)
			send(CMD_LATCH_RD, 18'($urandom), 8'($urandom), 2'($urandom));
		else
			send(CMD_LATCH_WR, 18'($urandom), 8'($urandom), 2'($urandom));
		if (!no_gaps && $urandom_range(0, 3) == 0)
			pause($urandom_range(1, 11));
	endtask

	initial begin
		sb = new();
		no_gaps = 0;
		start = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		command = CMD_LATCH_RD; address = 0; write_data = 0; latch_select = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pool[0] = 16'h0000;
		pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_N; i++) pool[i] = 16'($urandom);

		// Fill every plane byte of the pool in linear mode so no read ever sees
		// an unwritten location.
		for (int i = 0; i < POOL_N; i++)
			for (int p = 0; p < NUM_PLANES; p++)
				send(CMD_MEM_WR, {2'(p), pool[i]}, (i == 0) ? 8'hFF : 8'($urandom), 2'd0);
		send(CMD_MEM_RD, 18'h3FFFF, 8'h00, 2'd0);
		send(CMD_MEM_RD, 18'h00000, 8'h00, 2'd0);
		drain();

		// Directed pass: each write mode and op with both read modes, including
		// the colour compare with no plane taking part.
		for (int m = 0; m < 8; m++) begin
			cfg_val = '{8'((m * 5) & 15), 8'((m * 3) & 15), (m == 4) ? 8'h0F : 8'hA5,
				8'((m % 4) << 3 | m), 8'(m % 4), 8'(m), (m < 4) ? 8'hFF : 8'h3C,
				(m == 1) ? 8'h0 : 8'hF};
			program_regs();
			send(CMD_LATCH_WR, 18'h0, (m % 2) ? 8'hFF : 8'h00, 2'(m));
			send(CMD_MEM_WR, {2'(m), pool[1]}, 8'hC3, 2'd0);
			send(CMD_MEM_RD, {2'(m % 4), pool[1]}, 8'h00, 2'd0);
			drain();
		end

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				cfg_val = '{8'hF, 8'hF, 8'hFF, 8'h1F, 8'h3, 8'h7, 8'hFF, 8'hF};
			end else if (ph == 1) begin
				cfg_val = '{8'h0, 8'h0, 8'h00, 8'h00, 8'h0, 8'h0, 8'h00, 8'h0};
			end else begin
				cfg_val[REG_SET_RESET]     = 8'($urandom_range(0, 15));
				cfg_val[REG_ENABLE_SR]     = 8'($urandom_range(0, 15));
				cfg_val[REG_COLOR_COMPARE] = 8'($urandom);
				cfg_val[REG_ROTATE_OP]     = 8'($urandom_range(0, 31));
				cfg_val[REG_READ_MAP]      = 8'($urandom_range(0, 3));
				cfg_val[REG_ACCESS_MODE]   = 8'($urandom_range(0, 7));
				if (ph == 5) cfg_val[REG_ACCESS_MODE] = 8'(MODE_LINEAR | $urandom_range(0, 7));
				cfg_val[REG_BIT_MASK]      = 8'($urandom);
				cfg_val[REG_MAP_MASK]      = 8'($urandom_range(0, 15));
			end
			program_regs();
			no_gaps = (ph == 7);
			for (int i = 0; i < 100; i++) begin
				random_item();
				// Sender holds off until everything outstanding has come back.
				if (ph == 3 && i == 50) drain();
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
